FILE: design/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types, constants and helpers of the matrix multiply-accumulate unit.
// ----------------------------------------------------------------------------
package mma_pkg;

    localparam int MAX_DIM     = 8;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = 3;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int ELEM_W      = 16;
    localparam int CVAL_W      = 32;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int ACC_W       = 36;

    typedef enum logic [1:0] {
        ACT_LOAD_A  = 2'd0,
        ACT_LOAD_B  = 2'd1,
        ACT_LOAD_C  = 2'd2,
        ACT_COMPUTE = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_M     = 2'd0,
        REG_INNER_K    = 2'd1,
        REG_COLS_N     = 2'd2,
        REG_ACCUMULATE = 2'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [CFG_W-1:0] res;
        res = d;
        if (d == '0) begin
            res = CFG_W'(1);
        end else if (d > CFG_W'(MAX_DIM)) begin
            res = CFG_W'(MAX_DIM);
        end
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
        return ADDR_W'(r * MAX_DIM + c);
    endfunction

    function automatic logic [CVAL_W-1:0] sat32(input logic signed [ACC_W-1:0] s);
        logic [CVAL_W-1:0] res;
        res = s[CVAL_W-1:0];
        if (!(&s[ACC_W-1:CVAL_W-1]) && (|s[ACC_W-1:CVAL_W-1])) begin
            res = s[ACC_W-1] ? {1'b1, {(CVAL_W-1){1'b0}}} : {1'b0, {(CVAL_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

FILE: design/mma_ram.sv
// ----------------------------------------------------------------------------
// mma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/matrix_multiply_accumulate_unit.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_unit
// C = A x B or C += A x B over A, B and C held in on-chip RAMs.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one word per load or
// compute command. Load words write one A, B or C entry; the unit is ready
// again in the next cycle. A compute word starts a run that
// emits every C entry of the rows_m x cols_n area in row-major order on the
// output channel (o_out_valid / i_out_ready), o_last set on the final one.
// Each C entry reads one A and one B element per cycle through single read
// ports, then a multiply stage and an accumulate stage drain before the
// saturated sum is written back to C and registered out. No input word is
// accepted during a run. If the receiver stalls, the finished entry stays
// in the output register and the run holds the next sum until it is taken.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data;
// the user must write it only while idle, the unit does not enforce this.
// Reset returns the registers to 8 x 8 x 8, no accumulate, and marks all C
// entries as zero; A and B hold no reset value.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_unit
    import mma_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_action,
    input  logic [IDX_W-1:0]     i_row,
    input  logic [IDX_W-1:0]     i_col,
    input  logic signed [ELEM_W-1:0] i_element,
    input  logic signed [CVAL_W-1:0] i_prior,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [IDX_W-1:0]     o_out_row,
    output logic [IDX_W-1:0]     o_out_col,
    output logic signed [CVAL_W-1:0] o_value,
    output logic                 o_last
);

    // configuration
    logic [CFG_W-1:0] r_rows_m, r_inner_k, r_cols_n;
    logic             r_accumulate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_m     <= CFG_W'(MAX_DIM);
            r_inner_k    <= CFG_W'(MAX_DIM);
            r_cols_n     <= CFG_W'(MAX_DIM);
            r_accumulate <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_ROWS_M:     r_rows_m     <= i_cfg_data;
                REG_INNER_K:    r_inner_k    <= i_cfg_data;
                REG_COLS_N:     r_cols_n     <= i_cfg_data;
                REG_ACCUMULATE: r_accumulate <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [CFG_W-1:0] m_dim, k_dim, n_dim;
    assign m_dim = clamp_dim(r_rows_m);
    assign k_dim = clamp_dim(r_inner_k);
    assign n_dim = clamp_dim(r_cols_n);

    // control
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_i, r_j, r_t;
    logic             in_acc, load_ok, is_compute;
    logic             t_end, i_end, j_end, out_free, emit;
    logic             r_acc_done;

    assign in_acc     = i_in_valid && o_in_ready;
    assign is_compute = (t_action'(i_action) == ACT_COMPUTE);
    assign load_ok    = (32'(i_row) < MAX_DIM) && (32'(i_col) < MAX_DIM);
    assign t_end      = ({1'b0, r_t} == k_dim - CFG_W'(1));
    assign i_end      = ({1'b0, r_i} == m_dim - CFG_W'(1));
    assign j_end      = ({1'b0, r_j} == n_dim - CFG_W'(1));
    assign out_free   = !o_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        emit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && is_compute) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (t_end) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (r_acc_done && out_free) begin
                    emit    = 1'b1;
                    n_state = (i_end && j_end) ? ST_IDLE : ST_RUN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_t     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_i <= '0;
                r_j <= '0;
                r_t <= '0;
            end else if (r_state == ST_RUN) begin
                r_t <= t_end ? '0 : r_t + IDX_W'(1);
            end else if (emit) begin
                if (j_end) begin
                    r_j <= '0;
                    r_i <= r_i + IDX_W'(1);
                end else begin
                    r_j <= r_j + IDX_W'(1);
                end
            end
        end
    end

    // memories
    logic               a_we, b_we, c_we;
    logic [ADDR_W-1:0]  ld_addr, c_waddr, c_raddr;
    logic [CVAL_W-1:0]  c_wdata, c_rdata, sat_val;
    logic [ELEM_W-1:0]  a_rdata, b_rdata;
    logic               ld_en;

    assign ld_en   = in_acc && !is_compute && load_ok;
    assign ld_addr = addr_of(i_row, i_col);
    assign a_we    = ld_en && (t_action'(i_action) == ACT_LOAD_A);
    assign b_we    = ld_en && (t_action'(i_action) == ACT_LOAD_B);
    assign c_we    = (ld_en && (t_action'(i_action) == ACT_LOAD_C)) || emit;
    assign c_waddr = emit ? addr_of(r_i, r_j) : ld_addr;
    assign c_wdata = emit ? sat_val : i_prior;
    assign c_raddr = addr_of(r_i, r_j);

    mma_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (ld_addr),
        .i_wdata (i_element),
        .i_raddr (addr_of(r_i, r_t)),
        .o_rdata (a_rdata)
    );

    mma_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (ld_addr),
        .i_wdata (i_element),
        .i_raddr (addr_of(r_t, r_j)),
        .o_rdata (b_rdata)
    );

    mma_ram #(.WIDTH(CVAL_W), .DEPTH(STORE_DEPTH)) u_c_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    // C entries never written since reset read as zero
    logic [STORE_DEPTH-1:0] r_c_vld;
    logic                   r_c_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= '0;
        end else if (c_we) begin
            r_c_vld[c_waddr] <= 1'b1;
        end
        r_c_rd_vld <= r_c_vld[c_raddr];
    end

    // multiply-accumulate pipe
    logic                     r_s1_vld, r_s1_first, r_s1_last;
    logic                     r_s2_vld, r_s2_first, r_s2_last;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_base, r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_acc_done <= 1'b0;
        end else begin
            r_s1_vld <= (r_state == ST_RUN);
            r_s2_vld <= r_s1_vld;
            if (r_s2_vld && r_s2_last) begin
                r_acc_done <= 1'b1;
            end else if (emit) begin
                r_acc_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= (r_t == '0);
        r_s1_last  <= t_end;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_prod     <= $signed(a_rdata) * $signed(b_rdata);
        if (r_s1_vld && r_s1_first) begin
            r_base <= (r_accumulate && r_c_rd_vld)
                    ? {{(ACC_W-CVAL_W){c_rdata[CVAL_W-1]}}, c_rdata} : '0;
        end
        if (r_s2_vld) begin
            r_acc <= (r_s2_first ? r_base : r_acc)
                   + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
    end

    assign sat_val = sat32(r_acc);

    // output register
    logic                     r_out_vld, r_out_last;
    logic [IDX_W-1:0]         r_out_row, r_out_col;
    logic signed [CVAL_W-1:0] r_out_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_row  <= r_i;
            r_out_col  <= r_j;
            r_out_val  <= sat_val;
            r_out_last <= i_end && j_end;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_value     = r_out_val;
    assign o_last      = r_out_last;

endmodule

FILE: design/mma_checker.sv
// ----------------------------------------------------------------------------
// mma_checker
// Port-level checks of the matrix multiply-accumulate unit, bound to the top.
// ----------------------------------------------------------------------------
module mma_checker
    import mma_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic [1:0]           i_action,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [IDX_W-1:0]     o_out_row,
    input logic [IDX_W-1:0]     o_out_col,
    input logic [CVAL_W-1:0]    o_value,
    input logic                 o_last
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value)
            && $stable(o_out_row) && $stable(o_out_col) && $stable(o_last))
        else $error("stalled output word changed");

    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (t_action'(i_action) == ACT_COMPUTE) |=> !o_in_ready)
        else $error("input taken right after compute word");

    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (t_action'(i_action) != ACT_COMPUTE) |=> o_in_ready)
        else $error("load word stalled the input");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind matrix_multiply_accumulate_unit mma_checker u_mma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_action    (i_action),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_row   (o_out_row),
    .o_out_col   (o_out_col),
    .o_value     (o_value),
    .o_last      (o_last)
);
